// ===== hw/rtl/kmpr_pkg.sv =====
package kmpr_pkg;

    localparam int KEY_COUNT    = 40;
    localparam int COLS_PER_ROW = 5;
    localparam int ROW_COUNT    = 8;

    localparam int FUNC_W  = 3;
    localparam int INDEX_W = 6;
    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 16;
    localparam int ROW_W   = 3;

    // operation codes on the func field
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ASSIGN  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PRESS   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;

    localparam logic [INDEX_W-1:0]      KEY_NONE = 6'd40;
    localparam logic [COLS_PER_ROW-1:0] ROW_IDLE = 5'h1F;

    // decoded operation handed from the decoder to the key map
    typedef struct packed {
        logic                 clr_all;
        logic                 set_en;
        logic [INDEX_W-1:0]   set_idx;
        logic                 set_val;
        logic                 rd_hit;
        logic [ROW_W-1:0]     rd_row;
    } t_key_op;

    // map a character code to its key number, KEY_NONE when unknown
    function automatic logic [INDEX_W-1:0] key_num_of(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0]  c;
        logic [INDEX_W-1:0] k;
        c = code;
        if (code >= 8'h61 && code <= 8'h7A) begin
            c = code - 8'd32;
        end
        case (c)
            8'h20: k = 6'd0;   // space
            8'h2F: k = 6'd1;   // slash
            8'h4D: k = 6'd2;
            8'h4E: k = 6'd3;
            8'h42: k = 6'd4;
            8'h0D: k = 6'd5;   // carriage return
            8'h0A: k = 6'd5;   // line feed shares the enter key
            8'h4C: k = 6'd6;
            8'h4B: k = 6'd7;
            8'h4A: k = 6'd8;
            8'h48: k = 6'd9;
            8'h50: k = 6'd10;
            8'h4F: k = 6'd11;
            8'h49: k = 6'd12;
            8'h55: k = 6'd13;
            8'h59: k = 6'd14;
            8'h30: k = 6'd15;
            8'h39: k = 6'd16;
            8'h38: k = 6'd17;
            8'h37: k = 6'd18;
            8'h36: k = 6'd19;
            8'h31: k = 6'd20;
            8'h32: k = 6'd21;
            8'h33: k = 6'd22;
            8'h34: k = 6'd23;
            8'h35: k = 6'd24;
            8'h51: k = 6'd25;
            8'h57: k = 6'd26;
            8'h45: k = 6'd27;
            8'h52: k = 6'd28;
            8'h54: k = 6'd29;
            8'h41: k = 6'd30;
            8'h53: k = 6'd31;
            8'h44: k = 6'd32;
            8'h46: k = 6'd33;
            8'h47: k = 6'd34;
            8'h5C: k = 6'd35;  // backslash
            8'h5A: k = 6'd36;
            8'h58: k = 6'd37;
            8'h43: k = 6'd38;
            8'h56: k = 6'd39;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/kmpr_if.sv =====
interface kmpr_req_if
    import kmpr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [INDEX_W-1:0]  key_index;
    logic                key_on;
    logic [CHAR_W-1:0]   char_code;
    logic [ADDR_W-1:0]   port_address;

    modport source (output valid, func, key_index, key_on, char_code, port_address,
                    input ready);
    modport sink   (input valid, func, key_index, key_on, char_code, port_address,
                    output ready);
endinterface

interface kmpr_rsp_if
    import kmpr_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [COLS_PER_ROW-1:0] row_bits;

    modport source (output valid, row_bits, input ready);
    modport sink   (input valid, row_bits, output ready);
endinterface

// ===== hw/rtl/kmpr_decode.sv =====
module kmpr_decode
    import kmpr_pkg::*;
(
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [INDEX_W-1:0] i_key_index,
    input  logic               i_key_on,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [ADDR_W-1:0]  i_port_address,
    output t_key_op            o_op
);

    logic [INDEX_W-1:0] char_key;
    logic [ROW_W-1:0]   sel_row;
    logic               sel_hit;

    assign char_key = key_num_of(i_char_code);

    // find the highest zero among address bits 15 down to 8
    always_comb begin
        sel_row = '0;
        sel_hit = 1'b0;
        for (int r = ROW_COUNT - 1; r >= 0; r--) begin
            if (!i_port_address[ADDR_W - 1 - r]) begin
                sel_row = ROW_W'(r);
                sel_hit = 1'b1;
            end
        end
    end

    // build the operation from func
    always_comb begin
        o_op         = '0;
        o_op.rd_row  = sel_row;
        case (i_func)
            FUNC_CLEAR: begin
                o_op.clr_all = 1'b1;
            end
            FUNC_ASSIGN: begin
                o_op.set_en  = (i_key_index < INDEX_W'(KEY_COUNT));
                o_op.set_idx = i_key_index;
                o_op.set_val = i_key_on;
            end
            FUNC_PRESS, FUNC_RELEASE: begin
                o_op.set_en  = (char_key != KEY_NONE);
                o_op.set_idx = char_key;
                o_op.set_val = (i_func == FUNC_PRESS);
            end
            FUNC_READ: begin
                o_op.rd_hit = sel_hit;
            end
            default: begin
                o_op.clr_all = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/kmpr_keymap.sv =====
module kmpr_keymap
    import kmpr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_apply,
    input  t_key_op                 i_op,
    output logic [COLS_PER_ROW-1:0] o_row_bits
);

    logic [KEY_COUNT-1:0] r_key_map;
    logic [KEY_COUNT-1:0] n_key_map;
    logic [INDEX_W-1:0]   row_base;

    // apply clear or single-key update
    always_comb begin
        n_key_map = r_key_map;
        if (i_op.clr_all) begin
            n_key_map = '0;
        end else if (i_op.set_en) begin
            n_key_map[i_op.set_idx] = i_op.set_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_map <= '0;
        end else if (i_apply) begin
            r_key_map <= n_key_map;
        end
    end

    // read the selected half-row active low
    assign row_base = INDEX_W'(i_op.rd_row) * INDEX_W'(COLS_PER_ROW);
    assign o_row_bits = i_op.rd_hit ? ~r_key_map[row_base +: COLS_PER_ROW] : ROW_IDLE;

endmodule

// ===== hw/rtl/keyboard_matrix_port_read_core.sv =====
// Channel   Dir  Payload                                            Handshake
// i_req     in   func, key_index, key_on, char_code, port_address  valid/ready
// o_rsp     out  row_bits (read port only)                          valid/ready
//
// One transaction per cycle sustained while results are taken; a read result is
// registered first in the input register, then in the result register.
// The key map update and half-row read share one combinational pass.
// Synchronous active-low reset clears the key map and both valid flags.
// A stalled result holds the transaction in the input register; new requests
// are accepted while that register is empty or its transaction advances.
module keyboard_matrix_port_read_core
    import kmpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    kmpr_req_if.sink    i_req,
    kmpr_rsp_if.source  o_rsp
);

    logic                    r_in_valid;
    logic [FUNC_W-1:0]       r_func;
    logic [INDEX_W-1:0]      r_key_index;
    logic                    r_key_on;
    logic [CHAR_W-1:0]       r_char_code;
    logic [ADDR_W-1:0]       r_port_address;
    logic                    r_out_valid;
    logic [COLS_PER_ROW-1:0] r_row_bits;

    t_key_op                 op;
    logic [COLS_PER_ROW-1:0] row_bits;
    logic                    advance;
    logic                    is_read;

    // advance the held transaction when the result side has room
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign is_read     = (r_func == FUNC_READ);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_func         <= i_req.func;
            r_key_index    <= i_req.key_index;
            r_key_on       <= i_req.key_on;
            r_char_code    <= i_req.char_code;
            r_port_address <= i_req.port_address;
        end
    end

    kmpr_decode u_decode (
        .i_func         (r_func),
        .i_key_index    (r_key_index),
        .i_key_on       (r_key_on),
        .i_char_code    (r_char_code),
        .i_port_address (r_port_address),
        .o_op           (op)
    );

    kmpr_keymap u_keymap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_apply    (advance),
        .i_op       (op),
        .o_row_bits (row_bits)
    );

    // result register: load on a read, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= is_read;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_read) begin
            r_row_bits <= row_bits;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.row_bits = r_row_bits;

endmodule

// ===== tb/sv/tb_keyboard_matrix_port_read_core.sv =====
`timescale 1ns / 1ps

module tb_keyboard_matrix_port_read_core;
    import kmpr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] idx;
        logic               on;
        logic [CHAR_W-1:0]  chr;
        logic [ADDR_W-1:0]  addr;
    } t_key_req;

    // Track the pressed-key map and hold the half-row reads still owed by the block
    class t_key_map_scoreboard;
        logic [KEY_COUNT-1:0]    keys;
        logic [COLS_PER_ROW-1:0] row_reads_q[$];
        string                   key_chars;
        int                      errors;
        int                      accepted;
        int                      reads_checked;

        function new();
            keys          = '0;
            errors        = 0;
            accepted      = 0;
            reads_checked = 0;
            key_chars     = " /MNB\015LKJHPOIUY0987612345QWERTASDFG\\ZXCV";
        endfunction

        function logic [CHAR_W-1:0] char_at(int k);
            return key_chars[k];
        endfunction

        // Fold case and line feed, then search the key legend
        function int key_of(logic [CHAR_W-1:0] code);
            logic [CHAR_W-1:0] c;
            c = code;
            if (c >= 8'h61 && c <= 8'h7A) begin
                c = c - 8'd32;
            end
            if (c == 8'h0A) begin
                c = 8'h0D;
            end
            for (int i = 0; i < KEY_COUNT; i++) begin
                if (key_chars[i] == c) begin
                    return i;
                end
            end
            return KEY_COUNT;
        endfunction

        function void put_key(int k, logic on);
            if (k < KEY_COUNT) begin
                keys[k] = on;
            end
        endfunction

        // First zero among A15..A8 picks the half-row; keys come back active low
        function logic [COLS_PER_ROW-1:0] half_row(logic [ADDR_W-1:0] addr);
            for (int r = 0; r < ROW_COUNT; r++) begin
                if (!addr[ADDR_W-1-r]) begin
                    return ~keys[r*COLS_PER_ROW +: COLS_PER_ROW];
                end
            end
            return ROW_IDLE;
        endfunction

        function void note_request(t_key_req t);
            accepted++;
            case (t.func)
                FUNC_CLEAR:   keys = '0;
                FUNC_ASSIGN:  put_key(int'(t.idx), t.on);
                FUNC_PRESS:   put_key(key_of(t.chr), 1'b1);
                FUNC_RELEASE: put_key(key_of(t.chr), 1'b0);
                FUNC_READ:    row_reads_q.push_back(half_row(t.addr));
                default:      ;
            endcase
        endfunction

        function void check_result(logic [COLS_PER_ROW-1:0] got);
            logic [COLS_PER_ROW-1:0] want;
            if (row_reads_q.size() == 0) begin
                errors++;
                $display("%0t: row read with none outstanding, expected none, actual %h",
                         $time, got);
            end else begin
                want = row_reads_q.pop_front();
                reads_checked++;
                if (got !== want) begin
                    errors++;
                    $display("%0t: row_bits mismatch, expected %h, actual %h",
                             $time, want, got);
                end
            end
        endfunction

        function int pending();
            return row_reads_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   cycles;

    t_key_map_scoreboard key_sb;

    kmpr_req_if req_if();
    kmpr_rsp_if rsp_if();

    keyboard_matrix_port_read_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_key_req make_req(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                                          logic on, logic [CHAR_W-1:0] chr,
                                          logic [ADDR_W-1:0] addr);
        t_key_req t;
        t.func = func;
        t.idx  = idx;
        t.on   = on;
        t.chr  = chr;
        t.addr = addr;
        return t;
    endfunction

    // Mostly key events and reads that hit a half-row, with a little noise
    function automatic t_key_req random_req();
        t_key_req t;
        int       sel;
        int       k;
        logic [7:0] hi;
        t.func = FUNC_CLEAR;
        t.idx  = INDEX_W'($urandom);
        t.on   = 1'($urandom);
        t.chr  = CHAR_W'($urandom);
        t.addr = ADDR_W'($urandom);
        sel    = $urandom_range(99);
        if (sel < 3) begin
            t.func = FUNC_CLEAR;
        end else if (sel < 6) begin
            t.func = FUNC_W'($urandom_range(5, 7));
        end else if (sel < 22) begin
            t.func = FUNC_ASSIGN;
            if ($urandom_range(9) == 0) begin
                t.idx = INDEX_W'($urandom_range(KEY_COUNT, 63));
            end else begin
                t.idx = INDEX_W'($urandom_range(0, KEY_COUNT - 1));
            end
        end else if (sel < 60) begin
            t.func = ($urandom_range(99) < 55) ? FUNC_PRESS : FUNC_RELEASE;
            if ($urandom_range(99) < 85) begin
                k     = $urandom_range(0, KEY_COUNT - 1);
                t.chr = key_sb.char_at(k);
                if (t.chr >= 8'h41 && t.chr <= 8'h5A && $urandom_range(1)) begin
                    t.chr = t.chr + 8'd32;
                end
                if (k == 5 && $urandom_range(1)) begin
                    t.chr = 8'h0A;
                end
            end
        end else begin
            t.func = FUNC_READ;
            sel    = $urandom_range(99);
            if (sel < 70) begin
                hi = 8'hFF;
                hi[$urandom_range(0, 7)] = 1'b0;
            end else if (sel < 85) begin
                hi = 8'($urandom);
            end else if (sel < 93) begin
                hi = 8'hFF;
            end else begin
                hi = 8'h00;
            end
            t.addr[15:8] = hi;
        end
        return t;
    endfunction

    // Offer one transaction after random idle cycles, return once accepted
    task automatic send_req(t_key_req t);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_if.valid        <= 1'b1;
        req_if.func         <= t.func;
        req_if.key_index    <= t.idx;
        req_if.key_on       <= t.on;
        req_if.char_code    <= t.chr;
        req_if.port_address <= t.addr;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        key_sb.note_request(t);
    endtask

    // Drop valid and hold off until every owed read has come back
    task automatic drain_reads();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (key_sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random(int n);
        repeat (n) begin
            send_req(random_req());
        end
    endtask

    // Edge cases: out-of-range indexes, case folding, unknown codes, unused funcs
    task automatic run_directed();
        send_req(make_req(FUNC_READ,    6'd0,  1'b0, 8'h00, 16'hFFFF));
        send_req(make_req(FUNC_READ,    6'd0,  1'b0, 8'h00, 16'h0000));
        send_req(make_req(FUNC_ASSIGN,  6'd0,  1'b1, 8'h00, 16'h0000));
        send_req(make_req(FUNC_ASSIGN,  6'd39, 1'b1, 8'hFF, 16'hFFFF));
        send_req(make_req(FUNC_ASSIGN,  6'd40, 1'b1, 8'h00, 16'h0000));
        send_req(make_req(FUNC_ASSIGN,  6'd63, 1'b1, 8'h00, 16'h0000));
        send_req(make_req(FUNC_READ,    6'd0,  1'b0, 8'h00, 16'h7F00));
        send_req(make_req(FUNC_READ,    6'd0,  1'b0, 8'h00, 16'hFEFF));
        send_req(make_req(FUNC_PRESS,   6'd0,  1'b0, 8'h61, 16'h0000));
        send_req(make_req(FUNC_PRESS,   6'd0,  1'b0, 8'h5A, 16'h0000));
        send_req(make_req(FUNC_PRESS,   6'd0,  1'b0, 8'h0A, 16'h0000));
        send_req(make_req(FUNC_PRESS,   6'd0,  1'b0, 8'h80, 16'h0000));
        send_req(make_req(FUNC_PRESS,   6'd0,  1'b0, 8'hFF, 16'h0000));
        send_req(make_req(FUNC_PRESS,   6'd0,  1'b0, 8'h60, 16'h0000));
        send_req(make_req(FUNC_PRESS,   6'd0,  1'b0, 8'h7B, 16'h0000));
        send_req(make_req(FUNC_PRESS,   6'd0,  1'b0, 8'h5C, 16'h0000));
        send_req(make_req(FUNC_READ,    6'd0,  1'b0, 8'h00, 16'hBFFF));
        send_req(make_req(FUNC_READ,    6'd0,  1'b0, 8'h00, 16'hFDFF));
        send_req(make_req(FUNC_RELEASE, 6'd0,  1'b0, 8'h7A, 16'h0000));
        send_req(make_req(FUNC_RELEASE, 6'd0,  1'b0, 8'h0D, 16'h0000));
        send_req(make_req(3'd5,         6'd0,  1'b0, 8'h00, 16'h0000));
        send_req(make_req(3'd7,         6'd63, 1'b1, 8'hFF, 16'h0000));
        send_req(make_req(FUNC_READ,    6'd0,  1'b0, 8'h00, 16'hFEFF));
        send_req(make_req(FUNC_ASSIGN,  6'd0,  1'b0, 8'h00, 16'h0000));
        send_req(make_req(FUNC_CLEAR,   6'd63, 1'b1, 8'hFF, 16'hFFFF));
        send_req(make_req(FUNC_READ,    6'd0,  1'b0, 8'h00, 16'h7FFF));
    endtask

    // Randomize result back-pressure at each falling edge
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check each result transaction as it is taken
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                key_sb.check_result(rsp_if.row_bits);
            end
        end
    end

    // Stop a hung run
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: cycle limit reached with %0d reads outstanding",
                 $time, key_sb.pending());
        $display("tb_keyboard_matrix_port_read_core: errors");
        $finish;
    end

    initial begin
        key_sb                = new();
        send_idle_pct         = 11;
        recv_idle_pct         = 79;
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.func           = FUNC_CLEAR;
        req_if.key_index      = '0;
        req_if.key_on         = 1'b0;
        req_if.char_code      = '0;
        req_if.port_address   = '0;

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(140);
        drain_reads();

        send_idle_pct = 79;
        recv_idle_pct = 11;
        run_random(140);
        drain_reads();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(145);
        drain_reads();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (key_sb.pending() != 0) begin
            key_sb.errors++;
            $display("%0t: %0d row reads never returned", $time, key_sb.pending());
        end
        $display("Accepted %0d key and port transactions, checked %0d half-row reads,",
                 key_sb.accepted, key_sb.reads_checked);
        $display("under sender-heavy, receiver-heavy and no-idle traffic.");
        if (key_sb.errors == 0) begin
            $display("tb_keyboard_matrix_port_read_core: clean");
        end else begin
            $display("tb_keyboard_matrix_port_read_core: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/kmpr_pkg.sv
hw/rtl/kmpr_if.sv
hw/rtl/kmpr_decode.sv
hw/rtl/kmpr_keymap.sv
hw/rtl/keyboard_matrix_port_read_core.sv
tb/sv/tb_keyboard_matrix_port_read_core.sv
